>>> rtl/prq_pkg.sv
// Shared types and constants for the priority run queue.
package prq_pkg;

  // Command codes carried on in_cmd.
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_PICK = 1'b1;

  // Width of one slice of the occupancy bitmap searched per cycle.
  localparam int GROUP_BITS = 32;
  localparam int GROUP_IDX_W = $clog2(GROUP_BITS);

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_HEAD  = 5'b00100,
    ST_LINK  = 5'b01000,
    ST_WRITE = 5'b10000
  } prq_state_t;

endpackage

>>> rtl/priority_run_queue.sv
// Priority run queue: per-level LIFO lists with an occupancy bitmap and a scan sequencer.
// Add: the sequencer reads the list head, then writes; the result strobes in the first idle cycle.
// Pick: scans G = 1..ceil(NUM_LEVELS/32) bitmap slices (up to 5 at 140 levels), then reads the
// head and the link, then writes; an empty queue finishes after all slices are scanned. The
// head and link memory reads are registered. One item is in flight at a time.
// Each result is shown for exactly one cycle on out_strobe; the receiver cannot stall it.
// Synchronous active-low reset clears the bitmap, the count, the sequencer and the result strobe only.
module priority_run_queue #(
  parameter int NUM_LEVELS = 140,
  parameter int NUM_TASKS  = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_cmd,
  input  logic [5:0] in_task_id,
  input  logic [7:0] in_priority_req,
  output logic       out_strobe,
  output logic       out_found,
  output logic [5:0] out_picked_task,
  output logic [6:0] out_queued_count
);
  import prq_pkg::*;

  localparam int NG  = (NUM_LEVELS + GROUP_BITS - 1) / GROUP_BITS;
  localparam int GW  = (NG > 1) ? $clog2(NG) : 1;
  localparam int LVW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int TW  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int LW  = $clog2(NUM_TASKS + 1);
  localparam int CW  = $clog2(NUM_TASKS + 1);

  prq_state_t state_r, state_nxt;
  logic [GW-1:0]  grp_r, grp_nxt;
  logic [LVW-1:0] lvl_r, lvl_nxt;
  logic           cmd_r, cmd_nxt;
  logic [5:0]     task_r, task_nxt;
  logic           task_ok_r, task_ok_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [NUM_LEVELS-1:0] occ_r, occ_nxt;

  logic       out_strobe_r, out_strobe_nxt;
  logic       out_found_r, out_found_nxt;
  logic [5:0] out_picked_r, out_picked_nxt;

  // Storage for list heads and per-task links.
  logic [TW-1:0] level_head [NUM_LEVELS];
  logic [LW-1:0] next_link  [NUM_TASKS];
  logic [TW-1:0] head_rd_r;
  logic [LW-1:0] link_rd_r;

  logic          head_we;
  logic [TW-1:0] head_wdata;
  logic          link_we;
  logic [LW-1:0] link_wdata;

  logic [NG*GROUP_BITS-1:0] occ_pad;
  logic [GROUP_BITS-1:0]    chunk;
  logic [GROUP_IDX_W-1:0]   hit_idx;
  logic                     hit_any;
  logic [LVW-1:0]           scan_lvl;
  logic [LVW-1:0]           add_lvl;
  logic                     accept;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // Saturate the requested priority to the last level.
  assign add_lvl = ({1'b0, in_priority_req} >= 9'(NUM_LEVELS)) ?
                   LVW'(NUM_LEVELS - 1) : LVW'(in_priority_req);

  // Select the current bitmap slice and find its lowest set bit.
  always_comb begin
    occ_pad = '0;
    occ_pad[NUM_LEVELS-1:0] = occ_r;
  end

  assign chunk   = occ_pad[grp_r*GROUP_BITS +: GROUP_BITS];
  assign hit_any = |chunk;

  always_comb begin
    hit_idx = '0;
    for (int i = GROUP_BITS - 1; i >= 0; i--) begin
      if (chunk[i]) hit_idx = GROUP_IDX_W'(i);
    end
  end

  assign scan_lvl = LVW'({grp_r, hit_idx});

  // Sequencer and state update.
  always_comb begin
    state_nxt      = state_r;
    grp_nxt        = grp_r;
    lvl_nxt        = lvl_r;
    cmd_nxt        = cmd_r;
    task_nxt       = task_r;
    task_ok_nxt    = task_ok_r;
    cnt_nxt        = cnt_r;
    occ_nxt        = occ_r;
    out_strobe_nxt = 1'b0;
    out_found_nxt  = out_found_r;
    out_picked_nxt = out_picked_r;
    head_we        = 1'b0;
    head_wdata     = '0;
    link_we        = 1'b0;
    link_wdata     = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt     = in_cmd;
          task_nxt    = in_task_id;
          task_ok_nxt = (11'(in_task_id) < 11'(NUM_TASKS));
          lvl_nxt     = add_lvl;
          grp_nxt     = '0;
          state_nxt   = (in_cmd == CMD_PICK) ? ST_SCAN : ST_HEAD;
        end
      end
      ST_SCAN: begin
        if (hit_any) begin
          lvl_nxt   = scan_lvl;
          state_nxt = ST_HEAD;
        end else if (grp_r == GW'(NG - 1)) begin
          // Empty queue: report nothing found.
          out_strobe_nxt = 1'b1;
          out_found_nxt  = 1'b0;
          out_picked_nxt = '0;
          state_nxt      = ST_IDLE;
        end else begin
          grp_nxt = grp_r + GW'(1);
        end
      end
      ST_HEAD: begin
        state_nxt = (cmd_r == CMD_PICK) ? ST_LINK : ST_WRITE;
      end
      ST_LINK: begin
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        out_strobe_nxt = 1'b1;
        state_nxt      = ST_IDLE;
        if (cmd_r == CMD_PICK) begin
          out_found_nxt  = 1'b1;
          out_picked_nxt = 6'(head_rd_r);
          if (link_rd_r >= LW'(NUM_TASKS)) begin
            occ_nxt[lvl_r] = 1'b0;
          end else begin
            head_we    = 1'b1;
            head_wdata = TW'(link_rd_r);
          end
          if (cnt_r != '0) cnt_nxt = cnt_r - CW'(1);
        end else begin
          out_found_nxt  = 1'b0;
          out_picked_nxt = '0;
          if (task_ok_r) begin
            // Push onto the front of the level's list.
            link_we    = 1'b1;
            link_wdata = occ_r[lvl_r] ? LW'(head_rd_r) : LW'(NUM_TASKS);
            head_we    = 1'b1;
            head_wdata = TW'(task_r);
            occ_nxt[lvl_r] = 1'b1;
            if (cnt_r < CW'(NUM_TASKS)) cnt_nxt = cnt_r + CW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      occ_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      occ_r        <= occ_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    grp_r        <= grp_nxt;
    lvl_r        <= lvl_nxt;
    cmd_r        <= cmd_nxt;
    task_r       <= task_nxt;
    task_ok_r    <= task_ok_nxt;
    out_found_r  <= out_found_nxt;
    out_picked_r <= out_picked_nxt;
  end

  // Head memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (head_we) level_head[lvl_r] <= head_wdata;
    head_rd_r <= level_head[lvl_r];
  end

  // Link memory: written on add, read at the picked head.
  always_ff @(posedge clk) begin
    if (link_we) next_link[TW'(task_r)] <= link_wdata;
    link_rd_r <= next_link[head_rd_r];
  end

  assign out_strobe       = out_strobe_r;
  assign out_found        = out_found_r;
  assign out_picked_task  = out_picked_r;
  assign out_queued_count = 7'(cnt_r);

  // A result never shows while an item is still in flight.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("result strobe while busy");

  // An accepted request always occupies the sequencer next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted request left sequencer idle");

  // The queued count never passes the task count.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(NUM_TASKS)) else $error("queued count out of range");

  // No result strobe directly follows another.
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("back-to-back result strobes");

endmodule
